[rtl/rounded_panel_alpha_compositor_defines.svh]
// assertion macros for the rounded panel alpha compositor
// no dependencies; included by modules that carry assertions
`ifndef ROUNDED_PANEL_ALPHA_COMPOSITOR_DEFINES_SVH
`define ROUNDED_PANEL_ALPHA_COMPOSITOR_DEFINES_SVH

// condition must never hold out of reset
`define RPAC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define RPAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rpac_pkg.sv]
// shared types, constants and blend functions of the panel compositor
// no dependencies
`default_nettype none

package rpac_pkg;

    typedef struct packed {
        logic [9:0]  panel_width;
        logic [9:0]  panel_height;
        logic [7:0]  corner_radius;
        logic [15:0] fill_color;
        logic [7:0]  fill_alpha;
        logic [15:0] border_color;
        logic [7:0]  border_alpha;
        logic [7:0]  sheen_rows;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic [15:0] bg;
        logic        in_shape;
        logic        border;
        logic [4:0]  sheen_alpha;
    } t_item;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } t_mix;

    typedef enum logic [2:0] {
        REG_PANEL_WIDTH,
        REG_PANEL_HEIGHT,
        REG_CORNER_RADIUS,
        REG_FILL_COLOR,
        REG_FILL_ALPHA,
        REG_BORDER_COLOR,
        REG_BORDER_ALPHA,
        REG_SHEEN_ROWS
    } t_reg_idx;

    localparam logic [15:0] SHEEN_COLOR = 16'hE7BF;
    localparam logic [4:0]  SHEEN_PEAK  = 5'd20;
    localparam logic [7:0]  ALPHA_FULL  = 8'd255;
    localparam logic [15:0] ROUND_BIAS  = 16'd127;
    localparam int          QUEUE_DEPTH = 4;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [15:0] mix_chan(input logic [7:0] d, input logic [7:0] s,
                                             input logic [7:0] a);
        logic [7:0] na;
        na = ALPHA_FULL - a;
        return ({8'd0, d} * {8'd0, na}) + ({8'd0, s} * {8'd0, a}) + ROUND_BIAS;
    endfunction

    function automatic t_mix mix_sums(input logic [15:0] under, input logic [15:0] over,
                                      input logic [7:0] a);
        t_mix m;
        m.r = mix_chan(widen5(under[15:11]), widen5(over[15:11]), a);
        m.g = mix_chan(widen6(under[10:5]), widen6(over[10:5]), a);
        m.b = mix_chan(widen5(under[4:0]), widen5(over[4:0]), a);
        return m;
    endfunction

    // exact divide by 255 for sums below 65280
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        return t[15:8];
    endfunction

    function automatic logic [15:0] pack565(input t_mix m);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = div255(m.r);
        g = div255(m.g);
        b = div255(m.b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

[rtl/rounded_panel_alpha_compositor.sv]
// Rounded panel alpha compositor: takes one pixel position with its RGB565
// background and returns the composited pixel, one pixel per clock sustained
// while nothing stalls. A four-stage front classifies the pixel (inside the
// rounded rectangle, on its one-pixel border, sheen alpha through a five-step
// restoring divider), a four-entry queue decouples it from a six-stage back
// that runs the fill, sheen and border blends, each as a multiply stage and a
// divide-by-255 and pack stage. The front stops accepting only when the
// queue is full and a classified request waits at its last stage. Registers
// are written over an APB-style port and must only change while the block is
// empty.
// depends on rpac_pkg, rpac_front, rpac_queue, rpac_back
`default_nettype none

module rounded_panel_alpha_compositor
    import rpac_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel request side
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [8:0]  i_pos_x,
    input  wire logic [8:0]  i_pos_y,
    input  wire logic [15:0] i_background_pixel,
    // result side
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_pixel_out,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    logic     f_push;
    t_item    f_item;
    logic     q_full;
    logic     q_valid;
    t_item    q_item;
    logic     b_pop;

    // register file, byte address is four times the index
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.panel_width   <= 10'd174;
            r_cfg.panel_height  <= 10'd121;
            r_cfg.corner_radius <= 8'd8;
            r_cfg.fill_color    <= 16'd32187;
            r_cfg.fill_alpha    <= 8'd34;
            r_cfg.border_color  <= 16'd59327;
            r_cfg.border_alpha  <= 8'd74;
            r_cfg.sheen_rows    <= 8'd14;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PANEL_WIDTH:   r_cfg.panel_width   <= pwdata[9:0];
                REG_PANEL_HEIGHT:  r_cfg.panel_height  <= pwdata[9:0];
                REG_CORNER_RADIUS: r_cfg.corner_radius <= pwdata[7:0];
                REG_FILL_COLOR:    r_cfg.fill_color    <= pwdata[15:0];
                REG_FILL_ALPHA:    r_cfg.fill_alpha    <= pwdata[7:0];
                REG_BORDER_COLOR:  r_cfg.border_color  <= pwdata[15:0];
                REG_BORDER_ALPHA:  r_cfg.border_alpha  <= pwdata[7:0];
                REG_SHEEN_ROWS:    r_cfg.sheen_rows    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        case (reg_idx)
            REG_PANEL_WIDTH:   prdata = {22'd0, r_cfg.panel_width};
            REG_PANEL_HEIGHT:  prdata = {22'd0, r_cfg.panel_height};
            REG_CORNER_RADIUS: prdata = {24'd0, r_cfg.corner_radius};
            REG_FILL_COLOR:    prdata = {16'd0, r_cfg.fill_color};
            REG_FILL_ALPHA:    prdata = {24'd0, r_cfg.fill_alpha};
            REG_BORDER_COLOR:  prdata = {16'd0, r_cfg.border_color};
            REG_BORDER_ALPHA:  prdata = {24'd0, r_cfg.border_alpha};
            REG_SHEEN_ROWS:    prdata = {24'd0, r_cfg.sheen_rows};
            default:           prdata = '0;
        endcase
    end

    // classification front
    rpac_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_background_pixel (i_background_pixel),
        .o_push             (f_push),
        .o_item             (f_item),
        .i_q_full           (q_full)
    );

    // decoupling queue
    rpac_queue #(
        .W     ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_item),
        .i_pop   (b_pop)
    );

    // blend back, last stage is the output register
    rpac_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (b_pop),
        .o_valid      (o_valid),
        .o_pixel_out  (o_pixel_out),
        .i_stall      (i_stall)
    );

endmodule

`default_nettype wire

[rtl/rpac_queue.sv]
// small fifo between the classifier front and the blend back
// depends on rounded_panel_alpha_compositor_defines.svh
`default_nettype none
`include "rounded_panel_alpha_compositor_defines.svh"

module rpac_queue #(
    parameter int W     = 23,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [W-1:0]      o_data,
    input  wire logic         i_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `RPAC_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CW'(DEPTH), "queue overfilled")
    `RPAC_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && !o_valid, "pop while empty")
    `RPAC_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full, "push while full")
    `RPAC_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop,
        r_count == $past(r_count) + 1'b1, "count did not follow push")

endmodule

`default_nettype wire

[rtl/rpac_front.sv]
// front: accepts pixels, runs the rounded-rectangle tests and the sheen alpha
// depends on rpac_pkg
`default_nettype none

module rpac_front
    import rpac_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [8:0]  i_pos_x,
    input  wire logic [8:0]  i_pos_y,
    input  wire logic [15:0] i_background_pixel,
    output logic             o_push,
    output t_item            o_item,
    input  wire logic        i_q_full
);
    localparam int CW  = 12;
    localparam int SQW = 20;
    localparam int NP  = 5;
    typedef logic signed [CW-1:0] t_coord;

    // center, left, right, up, down
    localparam t_coord OX [NP] = '{12'sd0, -12'sd1, 12'sd1, 12'sd0, 12'sd0};
    localparam t_coord OY [NP] = '{12'sd0, 12'sd0, 12'sd0, -12'sd1, 12'sd1};
    localparam t_coord ONE = 12'sd1;

    logic adv;

    // stage 0: captured request
    logic        r_v0;
    logic [8:0]  r_x0, r_y0;
    logic [15:0] r_bg0;
    // stage 1: corner offsets
    logic        r_v1;
    logic [15:0] r_bg1;
    logic        r_oob1 [NP];
    logic        r_str1 [NP];
    t_coord      r_dx1 [NP];
    t_coord      r_dy1 [NP];
    logic [12:0] r_num1;
    // stage 2: squares, first divide steps
    logic        r_v2;
    logic [15:0] r_bg2;
    logic        r_oob2 [NP];
    logic        r_str2 [NP];
    logic [SQW-1:0] r_sqx2 [NP];
    logic [SQW-1:0] r_sqy2 [NP];
    logic [15:0] r_radsq2;
    logic [12:0] r_rem2;
    logic [4:0]  r_q2;
    // stage 3: classified
    logic        r_v3;
    logic [15:0] r_bg3;
    logic        r_ins3, r_brd3;
    logic [4:0]  r_sa3;

    t_coord      w_eff, h_eff, rad;
    logic        n_oob1 [NP];
    logic        n_str1 [NP];
    t_coord      n_dx1 [NP];
    t_coord      n_dy1 [NP];
    logic [12:0] n_num1;
    logic [SQW-1:0] n_sqx2 [NP];
    logic [SQW-1:0] n_sqy2 [NP];
    logic [12:0] n_rem2;
    logic [4:0]  n_q2;
    logic        n_in3 [NP];
    logic [12:0] rem3;
    logic [4:0]  n_q3;

    assign adv     = !r_v3 || !i_q_full;
    assign o_stall = !adv;
    assign o_push  = r_v3 && !i_q_full;
    assign o_item  = '{bg: r_bg3, in_shape: r_ins3, border: r_brd3, sheen_alpha: r_sa3};

    // stage 1 logic
    always_comb begin
        t_coord px, py, cx, cy;
        logic [8:0] diff;
        w_eff = (int'(i_cfg.panel_width) > MAX_WIDTH) ? t_coord'(MAX_WIDTH)
                                                      : t_coord'(i_cfg.panel_width);
        h_eff = (int'(i_cfg.panel_height) > MAX_HEIGHT) ? t_coord'(MAX_HEIGHT)
                                                        : t_coord'(i_cfg.panel_height);
        rad   = t_coord'(i_cfg.corner_radius);
        for (int p = 0; p < NP; p++) begin
            px = t_coord'({3'b000, r_x0}) + OX[p];
            py = t_coord'({3'b000, r_y0}) + OY[p];
            n_oob1[p] = (px < 0) || (py < 0) || (px >= w_eff) || (py >= h_eff);
            n_str1[p] = ((px >= rad) && (px < w_eff - rad)) ||
                        ((py >= rad) && (py < h_eff - rad));
            cx = (px < rad) ? rad : (w_eff - rad - ONE);
            cy = (py < rad) ? rad : (h_eff - rad - ONE);
            n_dx1[p] = px - cx;
            n_dy1[p] = py - cy;
        end
        diff   = {1'b0, i_cfg.sheen_rows} - r_y0;
        n_num1 = (r_y0 < {1'b0, i_cfg.sheen_rows})
                 ? 13'(diff[7:0]) * 13'(SHEEN_PEAK) : '0;
    end

    // stage 2 logic
    always_comb begin
        logic signed [2*CW-1:0] prx, pry;
        logic [12:0] d;
        for (int p = 0; p < NP; p++) begin
            prx = r_dx1[p] * r_dx1[p];
            pry = r_dy1[p] * r_dy1[p];
            n_sqx2[p] = prx[SQW-1:0];
            n_sqy2[p] = pry[SQW-1:0];
        end
        n_rem2 = r_num1;
        n_q2   = '0;
        // zero sheen rows gives a zero quotient
        for (int k = 4; k >= 3; k--) begin
            d = 13'(i_cfg.sheen_rows) << k;
            if ((d != '0) && (n_rem2 >= d)) begin
                n_rem2 = n_rem2 - d;
                n_q2[k] = 1'b1;
            end
        end
    end

    // stage 3 logic
    always_comb begin
        logic [12:0] d;
        for (int p = 0; p < NP; p++) begin
            n_in3[p] = !r_oob2[p] &&
                       (r_str2[p] ||
                        ({1'b0, r_sqx2[p]} + {1'b0, r_sqy2[p]} <= (SQW + 1)'(r_radsq2)));
        end
        rem3 = r_rem2;
        n_q3 = r_q2;
        for (int k = 2; k >= 0; k--) begin
            d = 13'(i_cfg.sheen_rows) << k;
            if ((d != '0) && (rem3 >= d)) begin
                rem3 = rem3 - d;
                n_q3[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x0  <= i_pos_x;
            r_y0  <= i_pos_y;
            r_bg0 <= i_background_pixel;

            r_bg1  <= r_bg0;
            r_oob1 <= n_oob1;
            r_str1 <= n_str1;
            r_dx1  <= n_dx1;
            r_dy1  <= n_dy1;
            r_num1 <= n_num1;

            r_bg2    <= r_bg1;
            r_oob2   <= r_oob1;
            r_str2   <= r_str1;
            r_sqx2   <= n_sqx2;
            r_sqy2   <= n_sqy2;
            r_radsq2 <= {8'd0, i_cfg.corner_radius} * {8'd0, i_cfg.corner_radius};
            r_rem2   <= n_rem2;
            r_q2     <= n_q2;

            r_bg3  <= r_bg2;
            r_ins3 <= n_in3[0];
            r_brd3 <= n_in3[0] && !(n_in3[1] && n_in3[2] && n_in3[3] && n_in3[4]);
            r_sa3  <= n_q3;
        end
    end

endmodule

`default_nettype wire

[rtl/rpac_back.sv]
// back: fill, sheen and border blends, each a multiply stage and a pack stage
// depends on rpac_pkg
`default_nettype none

module rpac_back
    import rpac_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_item_valid,
    input  wire t_item       i_item,
    output logic             o_pop,
    output logic             o_valid,
    output logic [15:0]      o_pixel_out,
    input  wire logic        i_stall
);
    localparam int NS = 6;

    logic        adv;
    logic        r_v   [NS];
    logic [15:0] r_px  [NS];
    t_mix        r_sum [NS];
    logic        r_ins [NS];
    logic        r_brd [NS];
    logic [4:0]  r_sa  [NS];

    assign adv         = !r_v[NS-1] || !i_stall;
    assign o_pop       = adv && i_item_valid;
    assign o_valid     = r_v[NS-1];
    assign o_pixel_out = r_px[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (adv) begin
            r_v[0] <= i_item_valid;
            for (int s = 1; s < NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // fill
            r_px[0]  <= i_item.bg;
            r_sum[0] <= mix_sums(i_item.bg, i_cfg.fill_color, i_cfg.fill_alpha);
            r_ins[0] <= i_item.in_shape;
            r_brd[0] <= i_item.border;
            r_sa[0]  <= i_item.sheen_alpha;
            r_px[1]  <= r_ins[0] ? pack565(r_sum[0]) : r_px[0];
            // sheen, zero alpha leaves the pixel as is
            r_px[2]  <= r_px[1];
            r_sum[2] <= mix_sums(r_px[1], SHEEN_COLOR, {3'd0, r_sa[1]});
            r_px[3]  <= r_ins[2] ? pack565(r_sum[2]) : r_px[2];
            // border stroke
            r_px[4]  <= r_px[3];
            r_sum[4] <= mix_sums(r_px[3], i_cfg.border_color, i_cfg.border_alpha);
            r_px[5]  <= (r_ins[4] && r_brd[4]) ? pack565(r_sum[4]) : r_px[4];
            for (int s = 1; s < NS; s++) begin
                r_ins[s] <= r_ins[s-1];
                r_brd[s] <= r_brd[s-1];
                r_sa[s]  <= r_sa[s-1];
            end
            r_sum[1] <= r_sum[0];
            r_sum[3] <= r_sum[2];
            r_sum[5] <= r_sum[4];
        end
    end

endmodule

`default_nettype wire
